>>> rtl/gpk_pkg.sv
// shared constants for the guillotine rectangle packer
// field widths, status codes, register decode and parameter defaults; no dependencies
package gpk_pkg;

    localparam int FREE_DEPTH_DEF   = 64;
    localparam int PLACED_DEPTH_DEF = 256;
    localparam int COORD_MAX_DEF    = 4096;

    localparam int SIZE_W   = 13;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 12;
    localparam int HANDLE_W = 8;
    localparam int AREA_W   = 25;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [SIZE_W-1:0] ATLAS_RESET = 13'd1024;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    // register select is paddr bit 2
    localparam logic REG_ATLAS_WIDTH  = 1'b0;
    localparam logic REG_ATLAS_HEIGHT = 1'b1;

endpackage

>>> rtl/gpk_ifs.sv
// request and response channel interfaces of the rectangle packer
// depends on gpk_pkg for field widths
interface gpk_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [gpk_pkg::SIZE_W-1:0]   req_width;
    logic [gpk_pkg::SIZE_W-1:0]   req_height;
    logic [gpk_pkg::INDEX_W-1:0]  placed_index;

    modport source (output valid, func, req_width, req_height, placed_index, input ready);
    modport sink   (input valid, func, req_width, req_height, placed_index, output ready);
endinterface

interface gpk_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [gpk_pkg::STATUS_W-1:0]  status;
    logic [gpk_pkg::POS_W-1:0]     pos_x;
    logic [gpk_pkg::POS_W-1:0]     pos_y;
    logic [gpk_pkg::HANDLE_W-1:0]  handle;
    logic [gpk_pkg::AREA_W-1:0]    area_used;

    modport source (output valid, status, pos_x, pos_y, handle, area_used, input ready);
    modport sink   (input valid, status, pos_x, pos_y, handle, area_used, output ready);
endinterface

>>> rtl/gpk_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module gpk_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/guillotine_rect_packer.sv
// Guillotine atlas allocator. Free and placed rectangles live in two single-port-read rams
// (free list FREE_DEPTH entries, placed list PLACED_DEPTH entries); one request is worked at
// a time and gives exactly one response, unless atlas_width or atlas_height is written while
// it runs. An add reads each free entry once for the best-fit scan, appends a split piece
// when one is needed and, when an exact fit deletes an entry, shifts the free list down over
// it. A remove reads the placed entry, scans the free list once, shifts the placed list down,
// and for each further merge step adds one more scan and one deletion shift of the free list.
// These ram sweeps set how long a request takes. After reset and after each write of
// atlas_width or atlas_height the store is reinitialized, during which no request is taken.
// A new request is taken while the previous response still waits.
// depends on gpk_pkg, gpk_ifs and gpk_ram
module guillotine_rect_packer #(
    parameter int FREE_DEPTH   = gpk_pkg::FREE_DEPTH_DEF,
    parameter int PLACED_DEPTH = gpk_pkg::PLACED_DEPTH_DEF,
    parameter int COORD_MAX    = gpk_pkg::COORD_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    gpk_req_if.sink                     req,
    gpk_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gpk_pkg::APB_AW-1:0]  paddr,
    input  logic [gpk_pkg::APB_DW-1:0]  pwdata,
    output logic [gpk_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int CW   = $clog2(COORD_MAX + 1);
    localparam int IW   = gpk_pkg::SIZE_W;
    localparam int CMPW = (CW > IW) ? CW : IW;
    localparam int RW   = 4 * CW;
    localparam int FAW  = $clog2(FREE_DEPTH);
    localparam int FCW  = $clog2(FREE_DEPTH + 1);
    localparam int PAW  = $clog2(PLACED_DEPTH);
    localparam int PCW  = $clog2(PLACED_DEPTH + 1);
    localparam int SW   = (FCW > PCW) ? FCW : PCW;
    localparam int IXW  = (gpk_pkg::INDEX_W > PCW) ? gpk_pkg::INDEX_W : PCW;
    localparam int AW_  = gpk_pkg::AREA_W;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
    } rect_t;

    typedef enum logic [1:0] {M_RIGHT, M_LEFT, M_BELOW, M_ABOVE} mode_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ADD_SCAN, S_ADD_DEC, S_ADD_PIECE, S_RM_RD, S_RM_WAIT,
        S_RM_SCAN, S_RM_DEC, S_RM_POST, S_LOOP_ADJ, S_SHIFT, S_DONE
    } state_t;

    function automatic logic [CW-1:0] clamp_size(logic [IW-1:0] v);
        if (v == '0)
        begin
            return CW'(1);
        end
        if (32'(v) > COORD_MAX)
        begin
            return CW'(COORD_MAX);
        end
        return CW'(v);
    endfunction

    function automatic rect_t merge_rect(rect_t c, mode_t md, rect_t r);
        rect_t o;
        o = c;
        case (md)
            M_RIGHT:
            begin
                o.x = r.x;
                o.w = CW'(c.w + r.w);
            end
            M_LEFT:
            begin
                o.w = CW'(c.w + r.w);
            end
            M_BELOW:
            begin
                o.y = r.y;
                o.h = CW'(c.h + r.h);
            end
            default:
            begin
                o.h = CW'(c.h + r.h);
            end
        endcase
        return o;
    endfunction

    // configuration
    logic [IW-1:0] atlas_width_reg;
    logic [IW-1:0] atlas_height_reg;
    logic          cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == gpk_pkg::REG_ATLAS_WIDTH) ? gpk_pkg::APB_DW'(atlas_width_reg)
                                                           : gpk_pkg::APB_DW'(atlas_height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_width_reg  <= gpk_pkg::ATLAS_RESET;
            atlas_height_reg <= gpk_pkg::ATLAS_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == gpk_pkg::REG_ATLAS_HEIGHT)
            begin
                atlas_height_reg <= pwdata[IW-1:0];
            end
            else
            begin
                atlas_width_reg <= pwdata[IW-1:0];
            end
        end
    end

    // memories
    logic           free_we;
    logic [FAW-1:0] free_waddr;
    rect_t          free_wdata;
    logic [FAW-1:0] free_raddr;
    rect_t          free_rdata;
    logic           placed_we;
    logic [PAW-1:0] placed_waddr;
    rect_t          placed_wdata;
    logic [PAW-1:0] placed_raddr;
    rect_t          placed_rdata;

    gpk_ram #(.WIDTH(RW), .DEPTH(FREE_DEPTH)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    gpk_ram #(.WIDTH(RW), .DEPTH(PLACED_DEPTH)) u_placed_ram (
        .clk   (clk),
        .we    (placed_we),
        .waddr (placed_waddr),
        .wdata (placed_wdata),
        .raddr (placed_raddr),
        .rdata (placed_rdata)
    );

    // state
    state_t         state_reg;
    state_t         sh_ret_reg;
    logic [FCW-1:0] fc_reg;
    logic [PCW-1:0] pc_reg;
    logic [AW_-1:0] used_reg;
    logic [IW-1:0]  w_reg;
    logic [IW-1:0]  h_reg;
    logic [PAW-1:0] idx_reg;
    logic [AW_-1:0] area_reg;
    logic [FCW-1:0] sc_rd_reg;
    logic           sc_v_reg;
    logic [FAW-1:0] sc_idx_reg;
    logic           fnd_reg;
    logic [FAW-1:0] j_reg;
    mode_t          mode_reg;
    rect_t          c_reg;
    logic [2*CW-1:0] key_reg;
    rect_t          r_reg;
    rect_t          m_reg;
    rect_t          piece_reg;
    logic [FAW-1:0] cur_reg;
    logic           loop_reg;
    logic           sh_sel_reg;
    logic [SW-1:0]  sh_rd_reg;
    logic [SW-1:0]  sh_n_reg;
    logic           sh_v_reg;
    logic [SW-1:0]  sh_wa_reg;
    logic [gpk_pkg::STATUS_W-1:0] res_status_reg;
    logic [gpk_pkg::POS_W-1:0]    res_x_reg;
    logic [gpk_pkg::POS_W-1:0]    res_y_reg;
    logic [gpk_pkg::HANDLE_W-1:0] res_handle_reg;
    logic                         rsp_v_reg;
    logic [gpk_pkg::STATUS_W-1:0] out_status_reg;
    logic [gpk_pkg::POS_W-1:0]    out_x_reg;
    logic [gpk_pkg::POS_W-1:0]    out_y_reg;
    logic [gpk_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [AW_-1:0]               out_area_reg;

    // combinational helpers
    logic [2*IW-1:0] add_prod;
    logic [2*CW-1:0] rm_prod;
    logic            sc_go;
    logic            sh_go;
    logic            fits;
    logic [2*CW-1:0] key;
    logic            mt_hit;
    mode_t           mt_mode;
    logic [CW:0]     m_xend;
    logic [CW:0]     m_yend;
    logic [CW:0]     c_xend;
    logic [CW:0]     c_yend;
    logic [CW-1:0]   wc;
    logic [CW-1:0]   hc;
    logic [CW-1:0]   dw;
    logic [CW-1:0]   dh;
    logic            exact;
    logic            split_need;
    logic            add_ok;
    rect_t           upd;
    rect_t           piece;
    rect_t           merged;
    rect_t           place_rect;

    assign add_prod = req.req_width * req.req_height;
    assign rm_prod  = placed_rdata.w * placed_rdata.h;
    assign sc_go    = sc_rd_reg < fc_reg;
    assign sh_go    = sh_rd_reg < sh_n_reg;

    assign fits = (CMPW'(free_rdata.w) >= CMPW'(w_reg)) && (CMPW'(free_rdata.h) >= CMPW'(h_reg));
    assign key  = {CW'(free_rdata.w - CW'(w_reg)), CW'(free_rdata.h - CW'(h_reg))};

    assign m_xend = (CW+1)'(m_reg.x) + (CW+1)'(m_reg.w);
    assign m_yend = (CW+1)'(m_reg.y) + (CW+1)'(m_reg.h);
    assign c_xend = (CW+1)'(free_rdata.x) + (CW+1)'(free_rdata.w);
    assign c_yend = (CW+1)'(free_rdata.y) + (CW+1)'(free_rdata.h);

    always_comb
    begin
        mt_hit  = 1'b0;
        mt_mode = M_RIGHT;
        if (free_rdata.h == m_reg.h && free_rdata.y == m_reg.y)
        begin
            if ((CW+1)'(free_rdata.x) == m_xend)
            begin
                mt_hit = 1'b1;
            end
            else if (c_xend == (CW+1)'(m_reg.x))
            begin
                mt_hit  = 1'b1;
                mt_mode = M_LEFT;
            end
        end
        else if (free_rdata.w == m_reg.w && free_rdata.x == m_reg.x)
        begin
            if ((CW+1)'(free_rdata.y) == m_yend)
            begin
                mt_hit  = 1'b1;
                mt_mode = M_BELOW;
            end
            else if (c_yend == (CW+1)'(m_reg.y))
            begin
                mt_hit  = 1'b1;
                mt_mode = M_ABOVE;
            end
        end
    end

    assign wc         = CW'(w_reg);
    assign hc         = CW'(h_reg);
    assign dw         = c_reg.w - wc;
    assign dh         = c_reg.h - hc;
    assign exact      = (c_reg.w == wc) && (c_reg.h == hc);
    assign split_need = (c_reg.w != wc) && (c_reg.h != hc);
    assign add_ok     = fnd_reg && (w_reg != '0) && (h_reg != '0)
                        && (pc_reg < PCW'(PLACED_DEPTH))
                        && !(split_need && fc_reg >= FCW'(FREE_DEPTH));
    assign merged     = merge_rect(c_reg, mode_reg, m_reg);

    always_comb
    begin
        place_rect   = c_reg;
        place_rect.w = wc;
        place_rect.h = hc;
        upd          = c_reg;
        piece        = c_reg;
        if (c_reg.h == hc)
        begin
            upd.x = CW'(c_reg.x + wc);
            upd.w = dw;
        end
        else if (c_reg.w == wc)
        begin
            upd.y = CW'(c_reg.y + hc);
            upd.h = dh;
        end
        else if (dh < dw)
        begin
            upd.y   = CW'(c_reg.y + hc);
            upd.h   = dh;
            upd.w   = wc;
            piece.x = CW'(c_reg.x + wc);
            piece.w = dw;
        end
        else
        begin
            upd.x   = CW'(c_reg.x + wc);
            upd.w   = dw;
            upd.h   = hc;
            piece.y = CW'(c_reg.y + hc);
            piece.h = dh;
        end
    end

    // ram port control
    always_comb
    begin
        free_we      = 1'b0;
        free_waddr   = j_reg;
        free_wdata   = merged;
        free_raddr   = sc_rd_reg[FAW-1:0];
        placed_we    = 1'b0;
        placed_waddr = pc_reg[PAW-1:0];
        placed_wdata = place_rect;
        placed_raddr = idx_reg;
        case (state_reg)
            S_INIT:
            begin
                free_we      = 1'b1;
                free_waddr   = '0;
                free_wdata.x = '0;
                free_wdata.y = '0;
                free_wdata.w = clamp_size(atlas_width_reg);
                free_wdata.h = clamp_size(atlas_height_reg);
            end
            S_ADD_DEC:
            begin
                placed_we  = add_ok;
                free_we    = add_ok && !exact;
                free_wdata = upd;
            end
            S_ADD_PIECE:
            begin
                free_we    = 1'b1;
                free_waddr = fc_reg[FAW-1:0];
                free_wdata = piece_reg;
            end
            S_RM_DEC:
            begin
                free_we = loop_reg && fnd_reg;
            end
            S_RM_POST:
            begin
                free_we = 1'b1;
                if (!fnd_reg)
                begin
                    free_waddr = fc_reg[FAW-1:0];
                    free_wdata = r_reg;
                end
            end
            S_SHIFT:
            begin
                if (sh_sel_reg)
                begin
                    placed_raddr = sh_rd_reg[PAW-1:0];
                    placed_we    = sh_v_reg;
                    placed_waddr = sh_wa_reg[PAW-1:0];
                    placed_wdata = placed_rdata;
                end
                else
                begin
                    free_raddr = sh_rd_reg[FAW-1:0];
                    free_we    = sh_v_reg;
                    free_waddr = sh_wa_reg[FAW-1:0];
                    free_wdata = free_rdata;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = rsp_v_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.pos_x     = out_x_reg;
    assign rsp.pos_y     = out_y_reg;
    assign rsp.handle    = out_handle_reg;
    assign rsp.area_used = out_area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            sh_ret_reg     <= S_DONE;
            fc_reg         <= FCW'(1);
            pc_reg         <= '0;
            used_reg       <= '0;
            w_reg          <= '0;
            h_reg          <= '0;
            idx_reg        <= '0;
            area_reg       <= '0;
            sc_rd_reg      <= '0;
            sc_v_reg       <= 1'b0;
            sc_idx_reg     <= '0;
            fnd_reg        <= 1'b0;
            j_reg          <= '0;
            mode_reg       <= M_RIGHT;
            c_reg          <= '0;
            key_reg        <= '0;
            r_reg          <= '0;
            m_reg          <= '0;
            piece_reg      <= '0;
            cur_reg        <= '0;
            loop_reg       <= 1'b0;
            sh_sel_reg     <= 1'b0;
            sh_rd_reg      <= '0;
            sh_n_reg       <= '0;
            sh_v_reg       <= 1'b0;
            sh_wa_reg      <= '0;
            res_status_reg <= gpk_pkg::ST_OK;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_handle_reg <= '0;
            rsp_v_reg      <= 1'b0;
            out_status_reg <= gpk_pkg::ST_OK;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_handle_reg <= '0;
            out_area_reg   <= '0;
        end
        else
        begin
            if (rsp.ready && state_reg != S_DONE)
            begin
                rsp_v_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT:
                begin
                    state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        w_reg          <= req.req_width;
                        h_reg          <= req.req_height;
                        area_reg       <= AW_'(add_prod);
                        res_status_reg <= gpk_pkg::ST_OK;
                        res_x_reg      <= '0;
                        res_y_reg      <= '0;
                        res_handle_reg <= '0;
                        sc_rd_reg      <= '0;
                        sc_v_reg       <= 1'b0;
                        fnd_reg        <= 1'b0;
                        if (req.func == gpk_pkg::FUNC_ADD)
                        begin
                            state_reg <= S_ADD_SCAN;
                        end
                        else if (IXW'(req.placed_index) >= IXW'(pc_reg))
                        begin
                            res_status_reg <= gpk_pkg::ST_BAD_INDEX;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= PAW'(req.placed_index);
                            state_reg <= S_RM_RD;
                        end
                    end
                end
                S_ADD_SCAN, S_RM_SCAN:
                begin
                    if (sc_go)
                    begin
                        sc_rd_reg <= sc_rd_reg + FCW'(1);
                    end
                    sc_v_reg   <= sc_go;
                    sc_idx_reg <= sc_rd_reg[FAW-1:0];
                    if (sc_v_reg)
                    begin
                        if (state_reg == S_ADD_SCAN)
                        begin
                            if (fits && (!fnd_reg || key < key_reg))
                            begin
                                fnd_reg <= 1'b1;
                                key_reg <= key;
                                j_reg   <= sc_idx_reg;
                                c_reg   <= free_rdata;
                            end
                        end
                        else if (mt_hit && !fnd_reg && !(loop_reg && sc_idx_reg == cur_reg))
                        begin
                            fnd_reg  <= 1'b1;
                            j_reg    <= sc_idx_reg;
                            mode_reg <= mt_mode;
                            c_reg    <= free_rdata;
                        end
                    end
                    if (!sc_go && !sc_v_reg)
                    begin
                        state_reg <= (state_reg == S_ADD_SCAN) ? S_ADD_DEC : S_RM_DEC;
                    end
                end
                S_ADD_DEC:
                begin
                    if (!fnd_reg || w_reg == '0 || h_reg == '0)
                    begin
                        res_status_reg <= gpk_pkg::ST_NO_FIT;
                        state_reg      <= S_DONE;
                    end
                    else if (!add_ok)
                    begin
                        res_status_reg <= gpk_pkg::ST_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        res_x_reg      <= gpk_pkg::POS_W'(c_reg.x);
                        res_y_reg      <= gpk_pkg::POS_W'(c_reg.y);
                        res_handle_reg <= gpk_pkg::HANDLE_W'(pc_reg);
                        pc_reg         <= pc_reg + PCW'(1);
                        used_reg       <= used_reg + area_reg;
                        piece_reg      <= piece;
                        if (exact)
                        begin
                            sh_sel_reg <= 1'b0;
                            sh_rd_reg  <= SW'(j_reg) + SW'(1);
                            sh_n_reg   <= SW'(fc_reg);
                            sh_v_reg   <= 1'b0;
                            sh_ret_reg <= S_DONE;
                            state_reg  <= S_SHIFT;
                        end
                        else if (split_need)
                        begin
                            state_reg <= S_ADD_PIECE;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_ADD_PIECE:
                begin
                    fc_reg    <= fc_reg + FCW'(1);
                    state_reg <= S_DONE;
                end
                S_RM_RD:
                begin
                    state_reg <= S_RM_WAIT;
                end
                S_RM_WAIT:
                begin
                    r_reg     <= placed_rdata;
                    m_reg     <= placed_rdata;
                    area_reg  <= AW_'(rm_prod);
                    loop_reg  <= 1'b0;
                    sc_rd_reg <= '0;
                    sc_v_reg  <= 1'b0;
                    fnd_reg   <= 1'b0;
                    state_reg <= S_RM_SCAN;
                end
                S_RM_DEC:
                begin
                    if (!loop_reg)
                    begin
                        if (!fnd_reg && fc_reg >= FCW'(FREE_DEPTH))
                        begin
                            res_status_reg <= gpk_pkg::ST_FULL;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            used_reg   <= used_reg - area_reg;
                            res_x_reg  <= gpk_pkg::POS_W'(r_reg.x);
                            res_y_reg  <= gpk_pkg::POS_W'(r_reg.y);
                            sh_sel_reg <= 1'b1;
                            sh_rd_reg  <= SW'(idx_reg) + SW'(1);
                            sh_n_reg   <= SW'(pc_reg);
                            sh_v_reg   <= 1'b0;
                            sh_ret_reg <= S_RM_POST;
                            state_reg  <= S_SHIFT;
                        end
                    end
                    else if (!fnd_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        // merged entry now sits at j; drop the one it absorbed
                        m_reg      <= merged;
                        sh_sel_reg <= 1'b0;
                        sh_rd_reg  <= SW'(cur_reg) + SW'(1);
                        sh_n_reg   <= SW'(fc_reg);
                        sh_v_reg   <= 1'b0;
                        sh_ret_reg <= S_LOOP_ADJ;
                        state_reg  <= S_SHIFT;
                    end
                end
                S_RM_POST:
                begin
                    if (!fnd_reg)
                    begin
                        fc_reg    <= fc_reg + FCW'(1);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        m_reg     <= merged;
                        cur_reg   <= j_reg;
                        loop_reg  <= 1'b1;
                        sc_rd_reg <= '0;
                        sc_v_reg  <= 1'b0;
                        fnd_reg   <= 1'b0;
                        state_reg <= S_RM_SCAN;
                    end
                end
                S_LOOP_ADJ:
                begin
                    cur_reg   <= (j_reg > cur_reg) ? FAW'(j_reg - FAW'(1)) : j_reg;
                    sc_rd_reg <= '0;
                    sc_v_reg  <= 1'b0;
                    fnd_reg   <= 1'b0;
                    state_reg <= S_RM_SCAN;
                end
                S_SHIFT:
                begin
                    if (sh_go)
                    begin
                        sh_rd_reg <= sh_rd_reg + SW'(1);
                    end
                    sh_v_reg  <= sh_go;
                    sh_wa_reg <= sh_rd_reg - SW'(1);
                    if (!sh_go && !sh_v_reg)
                    begin
                        if (sh_sel_reg)
                        begin
                            pc_reg <= pc_reg - PCW'(1);
                        end
                        else
                        begin
                            fc_reg <= fc_reg - FCW'(1);
                        end
                        state_reg <= sh_ret_reg;
                    end
                end
                S_DONE:
                begin
                    if (!rsp_v_reg || rsp.ready)
                    begin
                        rsp_v_reg      <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_x_reg      <= res_x_reg;
                        out_y_reg      <= res_y_reg;
                        out_handle_reg <= res_handle_reg;
                        out_area_reg   <= used_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_wr)
            begin
                // reinitialize the store
                fc_reg    <= FCW'(1);
                pc_reg    <= '0;
                used_reg  <= '0;
                state_reg <= S_INIT;
            end
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in progress");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && sh_v_reg) |-> (sh_wa_reg < sh_n_reg))
        else $error("shift write outside the occupied list");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (fc_reg <= FCW'(FREE_DEPTH) && pc_reg <= PCW'(PLACED_DEPTH)))
        else $error("list count beyond its depth");

endmodule
